// File: sv/rcti_pkg.sv
// ----------------------------------------------------------------------------
// rcti_pkg: shared types and constants for the pt1000 temperature inversion
// Word type, field widths, coefficient constants and unit request structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcti_pkg;

    // field widths
    localparam int RES_W  = 23;
    localparam int TEMP_W = 21;
    localparam int WORD_W = 64;
    localparam int SH_W   = 7;

    // parameter defaults
    localparam int FRAC_BITS_DEF    = 24;
    localparam int NEWTON_STEPS_DEF = 12;

    typedef logic signed [WORD_W-1:0] t_word;

    // coefficients in milliohm units
    localparam logic [WORD_W-1:0] KA      = (64'd39083 << 40) / 64'd10;
    localparam logic [WORD_W-1:0] KB      = (64'd5775 << 50) / 64'd10000;
    localparam logic [WORD_W-1:0] KC      = (64'd4183 << 51) / 64'd1000000000;
    localparam logic [WORD_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // closed form constants
    localparam logic [WORD_W-1:0] CF_BASE = 64'd390830 << 12;
    localparam logic [WORD_W-1:0] CF_DIV  = 64'd473088;
    localparam logic [WORD_W-1:0] CF_D0   = 64'd152748088900;
    localparam logic [RES_W-1:0]  R0_MOHM = 23'd1000000;
    localparam logic [37:0]       CF_K    = 38'd23100;

    // multiplier request
    typedef struct packed {
        logic              start;
        t_word             a;
        t_word             b;
        logic [SH_W-1:0]   shift;
    } t_mul_req;

    // divider request
    typedef struct packed {
        logic  start;
        t_word n;
        t_word d;
    } t_div_req;

endpackage

`default_nettype wire

// File: sv/rcti_in_if.sv
// ----------------------------------------------------------------------------
// rcti_in_if: input channel
// Valid/ready channel carrying one resistance item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcti_in_if import rcti_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] resistance_mohm;

    modport source (output valid, output resistance_mohm, input ready);
    modport sink   (input valid, input resistance_mohm, output ready);
endinterface

`default_nettype wire

// File: sv/rcti_out_if.sv
// ----------------------------------------------------------------------------
// rcti_out_if: output channel
// Valid/ready channel carrying one temperature item with its valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcti_out_if import rcti_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_mdeg;
    logic                     valid_res;

    modport source (output valid, output temperature_mdeg, output valid_res, input ready);
    modport sink   (input valid, input temperature_mdeg, input valid_res, output ready);
endinterface

`default_nettype wire

// File: sv/rtd_cvd_temperature_inversion.sv
// ----------------------------------------------------------------------------
// rtd_cvd_temperature_inversion: pt1000 resistance to temperature
// Sequencer around a shared multiplier, a serial divider and a serial root.
// ----------------------------------------------------------------------------
// usage
//   i_in_chan takes one resistance item in milliohms; o_out_chan returns one
//   temperature item in millidegrees with a valid flag (0 for zero
//   resistance or above about 7612 ohm, temperature then 0).
//   one item is worked at a time; i_in_chan.ready is high only when idle.
//   at or above 1000 ohm: a 32-step square root and one or two divisions.
//   below 1000 ohm: each newton step runs nine multiplies on the shared
//   32x32 multiplier plus one division, for up to NEWTON_STEPS steps.
//   the divider produces one bit per cycle and the multiplier accumulates
//   four partial products per multiply.
//   the finished result sits in an output register; a new item is accepted
//   while it waits, and the sequencer holds its next result until the
//   receiver takes the previous one.
//   synchronous reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtd_cvd_temperature_inversion import rcti_pkg::*; #(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcti_in_if.sink    i_in_chan,
    rcti_out_if.source o_out_chan
);

    localparam int SW = $clog2(NEWTON_STEPS + 1);

    localparam t_word ONE      = 64'sd1 <<< FRAC_BITS;
    localparam t_word HALF     = ONE >>> 1;
    localparam t_word KA_F     = t_word'((64'd39083 << FRAC_BITS) / 64'd10);
    localparam t_word T_INIT   = -64'sd20 * ONE;
    localparam t_word T_MIN    = -64'sd200 * ONE;
    localparam t_word T_MAX    = 64'sd850 * ONE;
    localparam t_word OFF100   = 64'sd100 * ONE;
    localparam t_word OFF75    = 64'sd75 * ONE;
    localparam t_word EST0     = 64'sd1000000 * ONE;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SETUP = 9'b000000010,
        S_SQRT  = 9'b000000100,
        S_NSTEP = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_MWAIT = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_DWAIT = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    typedef enum logic [3:0] {
        OP_T2, OP_T3, OP_C1, OP_CT, OP_PA, OP_PB, OP_DB, OP_D1, OP_D2
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [RES_W-1:0] r_rin, n_rin;
    t_word  r_t, n_t, r_t2, n_t2, r_tmp, n_tmp, r_acc, n_acc, r_df, n_df;
    logic [SW-1:0] r_step, n_step;
    logic   r_cf, n_cf, r_second, n_second, r_ok, n_ok;
    logic [63:0] r_sq_v, n_sq_v, r_sq_res, n_sq_res, r_sq_bit, n_sq_bit;
    logic   r_ovalid, n_ovalid, r_ovres, n_ovres;
    logic signed [TEMP_W-1:0] r_otemp, n_otemp;

    t_mul_req mul_req;
    t_div_req div_req;
    logic     mul_done, div_done;
    t_word    mul_p, div_q;

    rcti_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    rcti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_q    (div_q)
    );

    // closed form discriminant
    logic [RES_W-1:0] cf_x;
    logic [37:0]      cf_prod;
    t_word            cf_d, target;
    always_comb begin
        cf_x    = r_rin - R0_MOHM;
        cf_prod = 38'(cf_x) * CF_K;
        cf_d    = $signed(CF_D0) - $signed({26'd0, cf_prod});
        target  = $signed(64'(r_rin) << FRAC_BITS);
    end

    // square root step
    logic [63:0] sq_sum;
    assign sq_sum = r_sq_res + r_sq_bit;

    // newton update and tolerance
    t_word       t_sub, t_clamp, q_clamp;
    logic [63:0] f_mag, f_k;
    logic        f_tol;
    always_comb begin
        t_sub   = r_t - div_q;
        t_clamp = (t_sub < T_MIN) ? T_MIN : ((t_sub > 64'sd0) ? 64'sd0 : t_sub);
        q_clamp = (div_q < 64'sd0) ? 64'sd0 : ((div_q > T_MAX) ? T_MAX : div_q);
        f_mag   = r_acc[63] ? 64'(-r_acc) : r_acc;
        f_k     = (f_mag << 10) - (f_mag << 4) - (f_mag << 3);
        f_tol   = f_k < $unsigned(ONE);
    end

    // rounding to millidegrees
    logic [63:0] t_mag, t_k, t_rnd;
    always_comb begin
        t_mag = r_t[63] ? 64'(-r_t) : r_t;
        t_k   = (t_mag << 10) - (t_mag << 4) - (t_mag << 3);
        t_rnd = (t_k + $unsigned(HALF)) >> FRAC_BITS;
    end

    // multiplier operand select
    always_comb begin
        mul_req.start = 1'b0;
        unique case (r_op)
            OP_T2: begin mul_req.a = r_t;   mul_req.b = r_t;          mul_req.shift = SH_W'(FRAC_BITS); end
            OP_T3: begin mul_req.a = r_t2;  mul_req.b = r_t;          mul_req.shift = SH_W'(FRAC_BITS); end
            OP_C1: begin mul_req.a = KC;    mul_req.b = r_tmp;        mul_req.shift = SH_W'(51); end
            OP_CT: begin mul_req.a = r_tmp; mul_req.b = r_t - OFF100; mul_req.shift = SH_W'(FRAC_BITS); end
            OP_PA: begin mul_req.a = KA;    mul_req.b = r_t;          mul_req.shift = SH_W'(40); end
            OP_PB: begin mul_req.a = KB;    mul_req.b = r_t2;         mul_req.shift = SH_W'(50); end
            OP_DB: begin mul_req.a = KB;    mul_req.b = r_t;          mul_req.shift = SH_W'(49); end
            OP_D1: begin mul_req.a = KC;    mul_req.b = r_t2;         mul_req.shift = SH_W'(49); end
            OP_D2: begin mul_req.a = r_tmp; mul_req.b = r_t - OFF75;  mul_req.shift = SH_W'(FRAC_BITS); end
            default: begin mul_req.a = r_t; mul_req.b = r_t;          mul_req.shift = SH_W'(FRAC_BITS); end
        endcase
        if (r_state == S_MUL) mul_req.start = 1'b1;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_rin    = r_rin;
        n_t      = r_t;
        n_t2     = r_t2;
        n_tmp    = r_tmp;
        n_acc    = r_acc;
        n_df     = r_df;
        n_step   = r_step;
        n_cf     = r_cf;
        n_second = r_second;
        n_ok     = r_ok;
        n_sq_v   = r_sq_v;
        n_sq_res = r_sq_res;
        n_sq_bit = r_sq_bit;
        n_ovalid = r_ovalid;
        n_ovres  = r_ovres;
        n_otemp  = r_otemp;
        div_req.start = 1'b0;
        div_req.n     = r_acc;
        div_req.d     = r_df;

        // output register drains
        if (r_ovalid && o_out_chan.ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_chan.valid) begin
                    n_rin   = i_in_chan.resistance_mohm;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_ok = 1'b0;
                n_t  = '0;
                if (r_rin == '0) begin
                    n_state = S_FIN;
                end else if (r_rin >= R0_MOHM) begin
                    if (cf_d < 64'sd0) begin
                        n_state = S_FIN;
                    end else begin
                        n_sq_v   = {cf_d[39:0], 24'd0};
                        n_sq_res = '0;
                        n_sq_bit = 64'd1 << 62;
                        n_cf     = 1'b1;
                        n_second = 1'b0;
                        n_state  = S_SQRT;
                    end
                end else begin
                    n_cf    = 1'b0;
                    n_t     = T_INIT;
                    n_step  = '0;
                    n_state = S_NSTEP;
                end
            end
            S_SQRT: begin
                if (r_sq_bit != '0) begin
                    if (r_sq_v >= sq_sum) begin
                        n_sq_v   = r_sq_v - sq_sum;
                        n_sq_res = (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        n_sq_res = r_sq_res >> 1;
                    end
                    n_sq_bit = r_sq_bit >> 2;
                end else begin
                    div_req.start = 1'b1;
                    div_req.n     = $signed(CF_BASE - r_sq_res);
                    div_req.d     = $signed(CF_DIV);
                    n_state       = S_DWAIT;
                end
            end
            S_NSTEP: begin
                n_acc   = EST0 - target;
                n_op    = OP_T2;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_done) begin
                    n_state = S_MUL;
                    n_op    = t_op'(r_op + 4'd1);
                    unique case (r_op)
                        OP_T2:   n_t2  = mul_p;
                        OP_CT:   n_acc = r_acc - mul_p;
                        OP_PA:   n_acc = r_acc + mul_p;
                        OP_PB:   n_acc = r_acc - mul_p;
                        OP_DB:   n_df  = KA_F - mul_p;
                        OP_D2: begin
                            n_df    = r_df - mul_p;
                            n_state = S_CHK;
                        end
                        default: n_tmp = mul_p;
                    endcase
                end
            end
            S_CHK: begin
                if (r_df == 64'sd0) begin
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (div_done) begin
                    if (r_cf) begin
                        if (!r_second && div_q >= 64'sd0 && div_q <= T_MAX) begin
                            n_t     = div_q;
                            n_ok    = 1'b1;
                            n_state = S_FIN;
                        end else if (!r_second) begin
                            n_second      = 1'b1;
                            div_req.start = 1'b1;
                            div_req.n     = $signed(CF_BASE + r_sq_res);
                            div_req.d     = $signed(CF_DIV);
                        end else begin
                            n_t     = q_clamp;
                            n_ok    = 1'b1;
                            n_state = S_FIN;
                        end
                    end else begin
                        n_t = t_clamp;
                        if (f_tol || r_step == SW'(NEWTON_STEPS - 1)) begin
                            n_ok    = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            n_step  = r_step + 1'b1;
                            n_state = S_NSTEP;
                        end
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_out_chan.ready) begin
                    n_ovalid = 1'b1;
                    n_ovres  = r_ok;
                    n_otemp  = r_t[63] ? -$signed(t_rnd[TEMP_W-1:0])
                                       : $signed(t_rnd[TEMP_W-1:0]);
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_rin    <= n_rin;
        r_t      <= n_t;
        r_t2     <= n_t2;
        r_tmp    <= n_tmp;
        r_acc    <= n_acc;
        r_df     <= n_df;
        r_step   <= n_step;
        r_cf     <= n_cf;
        r_second <= n_second;
        r_ok     <= n_ok;
        r_sq_v   <= n_sq_v;
        r_sq_res <= n_sq_res;
        r_sq_bit <= n_sq_bit;
        r_ovres  <= n_ovres;
        r_otemp  <= n_otemp;
    end

    assign i_in_chan.ready             = (r_state == S_IDLE);
    assign o_out_chan.valid            = r_ovalid;
    assign o_out_chan.valid_res        = r_ovres;
    assign o_out_chan.temperature_mdeg = r_otemp;

endmodule

`default_nettype wire

// File: sv/rcti_mul.sv
// ----------------------------------------------------------------------------
// rcti_mul: multi-cycle signed multiply with right shift
// 64x64 magnitude product built from four 32x32 partial products, then
// shifted right, truncated toward zero and saturated to 2^63-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcti_mul import rcti_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output logic          o_done,
    output t_word         o_p
);

    logic [63:0]     r_ua, r_ub;
    logic            r_neg;
    logic [SH_W-1:0] r_sh;
    logic [127:0]    r_acc;
    logic [1:0]      r_k;
    logic            r_busy, r_fin, r_done;
    t_word           r_p;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh, shifted;
    logic [63:0]  rlo, rsat;

    // partial product select
    always_comb begin
        a_half = r_k[1] ? r_ua[63:32] : r_ua[31:0];
        b_half = r_k[0] ? r_ub[63:32] : r_ub[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case (r_k)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // shift, saturate and sign
    always_comb begin
        shifted = r_acc >> r_sh;
        rlo     = (|shifted[127:64]) ? MAG_MAX : shifted[63:0];
        rsat    = rlo[63] ? MAG_MAX : rlo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ua   <= i_req.a[63] ? 64'(-i_req.a) : i_req.a;
                r_ub   <= i_req.b[63] ? 64'(-i_req.b) : i_req.b;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_sh   <= i_req.shift;
                r_acc  <= '0;
                r_k    <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + pp_sh;
                r_k   <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_p    <= r_neg ? -$signed(rsat) : $signed(rsat);
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

// File: sv/rcti_div.sv
// ----------------------------------------------------------------------------
// rcti_div: bit-serial fractional divider
// Restoring division of |n|*2^FRAC_BITS by |d|, one quotient bit a cycle,
// low 64 quotient bits kept, saturated and signed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcti_div import rcti_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output t_word         o_q
);

    localparam int NB = WORD_W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_num;
    logic [63:0]   r_rem, r_ud, r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_fin, r_done, r_neg;
    t_word         r_res;

    logic [64:0] trial;
    logic        ge;
    logic [63:0] qsat;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[NB-1]};
        ge    = trial >= {1'b0, r_ud};
        qsat  = r_q[63] ? MAG_MAX : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= {(i_req.n[63] ? 64'(-i_req.n) : 64'(i_req.n)),
                           {FRAC_BITS{1'b0}}};
                r_ud   <= i_req.d[63] ? 64'(-i_req.d) : i_req.d;
                r_neg  <= i_req.n[63] ^ i_req.d[63];
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? 64'(trial - {1'b0, r_ud}) : trial[63:0];
                r_q   <= {r_q[62:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= r_neg ? -$signed(qsat) : $signed(qsat);
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

`default_nettype wire

// File: sv/rcti_chk.sv
// ----------------------------------------------------------------------------
// rcti_chk: port-level checks for the temperature inversion block
// Watches both channels and the reset, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcti_chk import rcti_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     i_in_ready,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic signed [TEMP_W-1:0] i_temp,
    input wire logic                     i_vres
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    // block is busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // an invalid item carries zero temperature
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_vres |-> i_temp == '0)
        else $error("invalid item with nonzero temperature");

    // temperature within sensor range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_vres |-> i_temp >= -21'sd200000 && i_temp <= 21'sd850000)
        else $error("temperature out of range");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind rtd_cvd_temperature_inversion rcti_chk u_rcti_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_chan.valid),
    .i_in_ready (i_in_chan.ready),
    .i_out_valid(o_out_chan.valid),
    .i_out_ready(o_out_chan.ready),
    .i_temp     (o_out_chan.temperature_mdeg),
    .i_vres     (o_out_chan.valid_res)
);

`default_nettype wire

// File: test/rcti_checker.sv
// ----------------------------------------------------------------------------
// rcti_checker: output checker for the pt1000 temperature inversion
// Watches both channels, predicts each temperature item from the accepted
// resistance and compares it field by field with the returned item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcti_checker import rcti_pkg::*; #(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcti_in_if        i_in_mon,
    rcti_out_if       i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } t_temp_item;

    localparam longint ONE = longint'(1) << FRAC_BITS;

    t_temp_item temp_expect_q[$];

    // magnitude with saturation to 2^63-1
    function automatic longint signed_sat(logic [63:0] m, bit neg);
        if (m > MAG_MAX) m = MAG_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // (a*b)>>s on a 128-bit magnitude product, truncated toward zero
    function automatic longint prod_shift(longint a, longint b, int s);
        logic [127:0] p;
        logic [127:0] r;
        p = 128'(mag(a)) * 128'(mag(b));
        r = p >> s;
        if (r[127:64] != 0) r[63:0] = MAG_MAX;
        return signed_sat(r[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint frac_div(longint n, longint d);
        logic [127:0] q;
        q = (128'(mag(n)) << FRAC_BITS) / 128'(mag(d));
        return signed_sat(q[63:0], (n < 0) != (d < 0));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // newton iteration on the full quartic below 1000 ohm
    function automatic longint newton_temp(longint r);
        longint target, t, t2, t3, cterm, est, f, df, ka_f;
        target = r <<< FRAC_BITS;
        t = -20 * ONE;
        ka_f = longint'((64'd39083 << FRAC_BITS) / 64'd10);
        for (int i = 0; i < NEWTON_STEPS; i++) begin
            t2 = prod_shift(t, t, FRAC_BITS);
            t3 = prod_shift(t2, t, FRAC_BITS);
            cterm = prod_shift(prod_shift(KC, t3, 51), t - 100 * ONE, FRAC_BITS);
            est = 1000000 * ONE + prod_shift(KA, t, 40) - prod_shift(KB, t2, 50) - cterm;
            f = est - target;
            df = ka_f - prod_shift(KB, t, 49)
                 - prod_shift(prod_shift(KC, t2, 49), t - 75 * ONE, FRAC_BITS);
            if (df == 0) break;
            t -= frac_div(f, df);
            if (t < -200 * ONE) t = -200 * ONE;
            if (t > 0) t = 0;
            if (mag(f) * 1000 < 64'(ONE)) break;
        end
        return t;
    endfunction

    function automatic t_temp_item predict_temp(logic [RES_W-1:0] res);
        t_temp_item it;
        longint d, t, t1, t2;
        logic [63:0] s, m;
        it = '0;
        if (res == 0) return it;
        if (res >= R0_MOHM) begin
            d = 64'sd152748088900 - 64'sd23100 * longint'(res - R0_MOHM);
            if (d < 0) return it;
            s = int_sqrt(64'(d) << 24);
            t1 = longint'(((CF_BASE - s) << (FRAC_BITS - 11)) / 64'd231);
            t2 = longint'(((CF_BASE + s) << (FRAC_BITS - 11)) / 64'd231);
            t = (t1 >= 0 && t1 <= 850 * ONE) ? t1 : t2;
            if (t < 0) t = 0;
            if (t > 850 * ONE) t = 850 * ONE;
        end else begin
            t = newton_temp(longint'(res));
        end
        m = (mag(t) * 1000 + (64'(ONE) >> 1)) >> FRAC_BITS;
        it.temp = TEMP_W'(signed_sat(m, t < 0));
        it.ok = 1'b1;
        return it;
    endfunction

    assign o_pending = temp_expect_q.size();

    // queue expectations and compare returned items
    always @(posedge i_clk) begin
        t_temp_item exp_item;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                temp_expect_q.push_back(predict_temp(i_in_mon.resistance_mohm));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (temp_expect_q.size() == 0) begin
                    $display("%0t: unexpected item temp=%0d valid_res=%0b", $time,
                             i_out_mon.temperature_mdeg, i_out_mon.valid_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = temp_expect_q.pop_front();
                    if (exp_item.temp !== i_out_mon.temperature_mdeg ||
                        exp_item.ok !== i_out_mon.valid_res) begin
                        $display("%0t: mismatch temp exp=%0d act=%0d valid_res exp=%0b act=%0b",
                                 $time, exp_item.temp, i_out_mon.temperature_mdeg,
                                 exp_item.ok, i_out_mon.valid_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the pt1000 temperature inversion
// Drives directed and random resistances with random gaps and stalls, one
// long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rcti_pkg::*;

    localparam int N_RANDOM    = 560;
    localparam longint LIMIT   = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    longint cycle_count = 0;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;

    rcti_in_if  in_chan ();
    rcti_out_if out_chan ();

    rtd_cvd_temperature_inversion DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    rcti_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_chan),
        .i_out_mon    (out_chan),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[rtd_cvd_temperature_inversion] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int gap;
        out_chan.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_off) begin
                out_chan.ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_chan.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_chan.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_chan.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_res(logic [RES_W-1:0] r);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.resistance_mohm <= r;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [RES_W-1:0] rand_res();
        case ($urandom_range(0, 9))
            0: return RES_W'($urandom());
            1: return RES_W'($urandom_range(1, 2000));
            2, 3, 4: return RES_W'($urandom_range(185000, 999999));
            5: return RES_W'($urandom_range(999000, 1001000));
            6: return RES_W'($urandom_range(7600000, 7620000));
            default: return RES_W'($urandom_range(1000000, 7612470));
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        logic [RES_W-1:0] directed[$];
        in_chan.valid = 1'b0;
        in_chan.resistance_mohm = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed = '{23'd0, 23'd1, 23'h7FFFFF, 23'h555555, 23'h2AAAAA, 23'd999999,
                     23'd1000000, 23'd1000001, 23'd185201, 23'd100000, 23'd400000,
                     23'd3904810, 23'd3905000, 23'd7612470, 23'd7612471, 23'd7612500,
                     23'd1385055, 23'd922000, 23'd5000000, 23'd2000};
        foreach (directed[i]) send_res(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 40) hold_off = 1'b1;
            send_res(rand_res());
        end
        in_chan.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[rtd_cvd_temperature_inversion] OK");
        end else begin
            $display("[rtd_cvd_temperature_inversion] ERROR");
        end
        $finish;
    end

endmodule
